// File: design/efm_pkg.sv
// efm_pkg: shared codes and constants of the emergency-stop frame monitor
// operation codes, status codes, register indexes, character codes, reset values
// no dependencies

package efm_pkg;

    // default width of the sequence number
    localparam int SEQ_BITS_DEFAULT = 32;

    // operation codes
    localparam logic [1:0] OP_BYTE = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_LINK = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_PRESSED = 2'd1;
    localparam logic [1:0] ST_FAULT   = 2'd2;

    // button values, none means no value seen yet
    localparam logic [1:0] BTN_NONE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [1:0] REG_TIMEOUT  = 2'd1;
    localparam logic [1:0] REG_LINE_LIM = 2'd2;

    // register reset values
    localparam logic [3:0]  DEBOUNCE_RESET = 4'd3;
    localparam logic [15:0] TIMEOUT_RESET  = 16'd100;
    localparam logic [11:0] LINE_LIM_RESET = 12'd1024;

    // heartbeat age saturation point
    localparam logic [16:0] AGE_MAX = 17'h1FFFF;

    // character codes
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // length of the magic token
    localparam logic [2:0] MAGIC_LEN = 3'd4;

    // number parse flags
    typedef struct packed {
        logic bad;
        logic digit;
        logic neg;
    } parse_flags_t;

    // characters of the magic token "EST1"
    function automatic logic [7:0] magic_char(input logic [1:0] pos);
        logic [7:0] ch;
        unique case (pos)
            2'd0:    ch = 8'h45;
            2'd1:    ch = 8'h53;
            2'd2:    ch = 8'h54;
            default: ch = 8'h31;
        endcase
        return ch;
    endfunction

endpackage

// File: design/estop_frame_monitor_core.sv
// estop_frame_monitor_core: parses emergency-stop text frames, debounces the button
// and tracks the heartbeat age; one result word for every input word
// depends on efm_pkg
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  in      | in        | in_valid/in_stall  | operation, data_byte
//  out     | out       | out_valid/out_stall| status, frame_accepted, sequence_restart
//  cfg     | in        | cfg_we             | cfg_index, cfg_data
//
//  one word per cycle when the output is not stalled; a word passes through the input
//  register and then the result register; the input register frees itself whenever
//  the result register is empty or taken, so while a finished result waits on a
//  stalled output, an empty input register still takes a new word; rst_n clears all
//  control and monitor state; status starts as fault; configuration is to be written
//  only while no word is in flight, which the block itself does not enforce

module estop_frame_monitor_core
    import efm_pkg::*;
#(
    parameter int SEQ_BITS = SEQ_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [7:0]  data_byte,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic        frame_accepted,
    output logic        sequence_restart,
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // token phases of the line parser
    typedef enum logic [2:0] {
        PH_PRE_MAGIC,
        PH_MAGIC,
        PH_PRE_SEQ,
        PH_SEQ,
        PH_PRE_BTN,
        PH_BTN,
        PH_TAIL,
        PH_FAIL
    } phase_t;

    localparam int PROD_BITS = SEQ_BITS + 4;

    // configuration registers
    logic [3:0]  debounce_reg;
    logic [15:0] timeout_reg;
    logic [11:0] line_limit_reg;

    // input register
    logic        in_valid_reg;
    logic [1:0]  in_op_reg;
    logic [7:0]  in_byte_reg;

    // result register
    logic        out_valid_reg;
    logic [1:0]  status_reg;
    logic        frame_accepted_reg;
    logic        sequence_restart_reg;

    // parser and monitor state
    phase_t              phase_reg, phase_next;
    logic [11:0]         partial_length_reg, partial_length_next;
    logic [2:0]          magic_pos_reg, magic_pos_next;
    logic [SEQ_BITS-1:0] seq_acc_reg, seq_acc_next;
    parse_flags_t        flags_reg, flags_next;
    logic [1:0]          btn_acc_reg, btn_acc_next;
    logic                last_seq_valid_reg, last_seq_valid_next;
    logic [SEQ_BITS-1:0] last_seq_reg, last_seq_next;
    logic [1:0]          raw_btn_reg, raw_btn_next;
    logic [1:0]          stable_btn_reg, stable_btn_next;
    logic [3:0]          agree_reg, agree_next;
    logic [16:0]         age_reg, age_next;
    logic [1:0]          cur_status_reg, cur_status_next;

    logic                accepted_next;
    logic                restart_next;

    // handshake
    logic in_accept;
    logic advance;

    // byte classification
    logic                 is_sp;
    logic                 is_dig;
    logic [3:0]           dig_val;
    logic [1:0]           dig_btn;
    logic [PROD_BITS-1:0] seq_prod;
    logic                 seq_ovf;

    // fall-through steps within one byte
    logic magic_step;
    logic pre_btn_step;
    logic tail_step;
    logic line_ok;

    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign frame_accepted   = frame_accepted_reg;
    assign sequence_restart = sequence_restart_reg;

    assign is_sp = (in_byte_reg == CH_SPACE) || (in_byte_reg == CH_TAB) ||
                   (in_byte_reg == CH_VT) || (in_byte_reg == CH_FF) ||
                   (in_byte_reg == CH_CR);
    assign is_dig  = (in_byte_reg >= CH_ZERO) && (in_byte_reg <= CH_NINE);
    assign dig_val = in_byte_reg[3:0];
    // a single button digit above one is out of range straight away
    assign dig_btn = (dig_val >= 4'd2) ? 2'd2 : dig_val[1:0];

    // acc * 10 + d, overflow when it leaves the sequence range
    assign seq_prod = {1'b0, seq_acc_reg, 3'b000} + {3'b000, seq_acc_reg, 1'b0}
                    + PROD_BITS'(dig_val);
    assign seq_ovf  = |seq_prod[PROD_BITS-1:SEQ_BITS];

    always_comb
    begin
        phase_next          = phase_reg;
        partial_length_next = partial_length_reg;
        magic_pos_next      = magic_pos_reg;
        seq_acc_next        = seq_acc_reg;
        flags_next          = flags_reg;
        btn_acc_next        = btn_acc_reg;
        last_seq_valid_next = last_seq_valid_reg;
        last_seq_next       = last_seq_reg;
        raw_btn_next        = raw_btn_reg;
        stable_btn_next     = stable_btn_reg;
        agree_next          = agree_reg;
        age_next            = age_reg;
        cur_status_next     = cur_status_reg;
        accepted_next       = 1'b0;
        restart_next        = 1'b0;
        magic_step          = 1'b0;
        pre_btn_step        = 1'b0;
        tail_step           = 1'b0;
        line_ok             = 1'b0;

        if (advance)
        begin
            case (in_op_reg)
                OP_BYTE:
                begin
                    if (in_byte_reg == CH_LF)
                    begin
                        // end of line: a frame is good after its button token
                        if (phase_reg == PH_TAIL)
                            line_ok = 1'b1;
                        else if (phase_reg == PH_BTN)
                            line_ok = flags_reg.digit &&
                                      ((btn_acc_reg == 2'd0) ||
                                       (btn_acc_reg == 2'd1 && !flags_reg.neg));
                        if (line_ok)
                        begin
                            accepted_next = 1'b1;
                            // sequence did not increase: debounce starts over
                            if (last_seq_valid_reg && (seq_acc_reg <= last_seq_reg))
                            begin
                                raw_btn_next    = BTN_NONE;
                                stable_btn_next = BTN_NONE;
                                agree_next      = 4'd0;
                                restart_next    = 1'b1;
                            end
                            last_seq_next       = seq_acc_reg;
                            last_seq_valid_next = 1'b1;
                            age_next            = 17'd0;
                            if (btn_acc_reg == raw_btn_next)
                            begin
                                if (agree_next < debounce_reg)
                                    agree_next = agree_next + 4'd1;
                            end
                            else
                            begin
                                raw_btn_next = btn_acc_reg;
                                agree_next   = 4'd1;
                            end
                            if (agree_next >= debounce_reg)
                                stable_btn_next = btn_acc_reg;
                        end
                        phase_next          = PH_PRE_MAGIC;
                        partial_length_next = 12'd0;
                        magic_pos_next      = 3'd0;
                        seq_acc_next        = '0;
                        flags_next          = '0;
                        btn_acc_next        = 2'd0;
                    end
                    else if (partial_length_reg >= line_limit_reg)
                    begin
                        // over-long line: drop it along with this byte
                        phase_next          = PH_PRE_MAGIC;
                        partial_length_next = 12'd0;
                        magic_pos_next      = 3'd0;
                        seq_acc_next        = '0;
                        flags_next          = '0;
                        btn_acc_next        = 2'd0;
                    end
                    else
                    begin
                        partial_length_next = partial_length_reg + 12'd1;
                        unique case (phase_reg)
                            PH_PRE_MAGIC:
                            begin
                                if (!is_sp)
                                begin
                                    magic_pos_next = 3'd0;
                                    flags_next     = '0;
                                    magic_step     = 1'b1;
                                end
                            end
                            PH_MAGIC:
                                magic_step = 1'b1;
                            PH_PRE_SEQ:
                            begin
                                if (!is_sp)
                                begin
                                    seq_acc_next = '0;
                                    flags_next   = '0;
                                    if (in_byte_reg == CH_PLUS || in_byte_reg == CH_MINUS)
                                    begin
                                        flags_next.neg = (in_byte_reg == CH_MINUS);
                                        phase_next     = PH_SEQ;
                                    end
                                    else if (is_dig)
                                    begin
                                        // first digit always fits
                                        flags_next.digit = 1'b1;
                                        seq_acc_next     = SEQ_BITS'(dig_val);
                                        phase_next       = PH_SEQ;
                                    end
                                    else
                                        phase_next = PH_FAIL;
                                end
                            end
                            PH_SEQ:
                            begin
                                if (is_dig)
                                begin
                                    flags_next.digit = 1'b1;
                                    if (seq_ovf)
                                        flags_next.bad = 1'b1;
                                    else
                                        seq_acc_next = seq_prod[SEQ_BITS-1:0];
                                end
                                else if (!flags_reg.digit || flags_reg.bad ||
                                         (flags_reg.neg && (seq_acc_reg != '0)))
                                    phase_next = PH_FAIL;
                                else
                                    pre_btn_step = 1'b1;
                            end
                            PH_PRE_BTN:
                                pre_btn_step = 1'b1;
                            PH_BTN:
                            begin
                                if (is_dig)
                                begin
                                    flags_next.digit = 1'b1;
                                    btn_acc_next = (btn_acc_reg == 2'd0) ? dig_btn : 2'd2;
                                end
                                else if (!(flags_reg.digit &&
                                           ((btn_acc_reg == 2'd0) ||
                                            (btn_acc_reg == 2'd1 && !flags_reg.neg))))
                                    phase_next = PH_FAIL;
                                else
                                    tail_step = 1'b1;
                            end
                            PH_TAIL:
                                tail_step = 1'b1;
                            PH_FAIL:
                                phase_next = PH_FAIL;
                            default:
                                phase_next = PH_FAIL;
                        endcase

                        // magic token, entered directly or from leading space
                        if (magic_step)
                        begin
                            if (is_sp)
                                phase_next = (magic_pos_next == MAGIC_LEN && !flags_next.bad)
                                           ? PH_PRE_SEQ : PH_FAIL;
                            else if (!magic_pos_next[2] &&
                                     in_byte_reg == magic_char(magic_pos_next[1:0]))
                            begin
                                magic_pos_next = magic_pos_next + 3'd1;
                                phase_next     = PH_MAGIC;
                            end
                            else
                            begin
                                flags_next.bad = 1'b1;
                                phase_next     = PH_MAGIC;
                            end
                        end

                        // start of the button token
                        if (pre_btn_step)
                        begin
                            if (is_sp)
                                phase_next = PH_PRE_BTN;
                            else
                            begin
                                btn_acc_next = 2'd0;
                                flags_next   = '0;
                                if (in_byte_reg == CH_PLUS || in_byte_reg == CH_MINUS)
                                begin
                                    flags_next.neg = (in_byte_reg == CH_MINUS);
                                    phase_next     = PH_BTN;
                                end
                                else if (is_dig)
                                begin
                                    flags_next.digit = 1'b1;
                                    btn_acc_next     = dig_btn;
                                    phase_next       = PH_BTN;
                                end
                                else
                                    phase_next = PH_FAIL;
                            end
                        end

                        // only whitespace may follow the button
                        if (tail_step)
                            phase_next = is_sp ? PH_TAIL : PH_FAIL;
                    end
                end
                OP_TICK:
                begin
                    if (age_reg != AGE_MAX)
                        age_next = age_reg + 17'd1;
                end
                OP_LINK:
                begin
                    phase_next          = PH_PRE_MAGIC;
                    partial_length_next = 12'd0;
                    magic_pos_next      = 3'd0;
                    seq_acc_next        = '0;
                    flags_next          = '0;
                    btn_acc_next        = 2'd0;
                    last_seq_valid_next = 1'b0;
                    last_seq_next       = '0;
                    raw_btn_next        = BTN_NONE;
                    stable_btn_next     = BTN_NONE;
                    agree_next          = 4'd0;
                    age_next            = 17'd0;
                    cur_status_next     = ST_FAULT;
                end
                default:
                    cur_status_next = cur_status_reg;
            endcase

            // status update, skipped for the unused operation code
            if (in_op_reg == OP_BYTE || in_op_reg == OP_TICK || in_op_reg == OP_LINK)
            begin
                if (age_next > {1'b0, timeout_reg})
                    cur_status_next = ST_FAULT;
                else if (stable_btn_next == 2'd0)
                    cur_status_next = ST_PRESSED;
                else if (stable_btn_next == 2'd1)
                    cur_status_next = ST_OK;
            end
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= DEBOUNCE_RESET;
            timeout_reg    <= TIMEOUT_RESET;
            line_limit_reg <= LINE_LIM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE: debounce_reg   <= cfg_data[3:0];
                REG_TIMEOUT:  timeout_reg    <= cfg_data;
                REG_LINE_LIM: line_limit_reg <= cfg_data[11:0];
                default:      debounce_reg   <= debounce_reg;
            endcase
        end
    end

    // handshake control and parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            phase_reg          <= PH_PRE_MAGIC;
            partial_length_reg <= 12'd0;
            magic_pos_reg      <= 3'd0;
            seq_acc_reg        <= '0;
            flags_reg          <= '0;
            btn_acc_reg        <= 2'd0;
            last_seq_valid_reg <= 1'b0;
            last_seq_reg       <= '0;
            raw_btn_reg        <= BTN_NONE;
            stable_btn_reg     <= BTN_NONE;
            agree_reg          <= 4'd0;
            age_reg            <= 17'd0;
            cur_status_reg     <= ST_FAULT;
        end
        else
        begin
            in_valid_reg       <= in_accept || (in_valid_reg && !advance);
            out_valid_reg      <= advance || (out_valid_reg && out_stall);
            phase_reg          <= phase_next;
            partial_length_reg <= partial_length_next;
            magic_pos_reg      <= magic_pos_next;
            seq_acc_reg        <= seq_acc_next;
            flags_reg          <= flags_next;
            btn_acc_reg        <= btn_acc_next;
            last_seq_valid_reg <= last_seq_valid_next;
            last_seq_reg       <= last_seq_next;
            raw_btn_reg        <= raw_btn_next;
            stable_btn_reg     <= stable_btn_next;
            agree_reg          <= agree_next;
            age_reg            <= age_next;
            cur_status_reg     <= cur_status_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_op_reg   <= operation;
            in_byte_reg <= data_byte;
        end
        if (advance)
        begin
            status_reg           <= cur_status_next;
            frame_accepted_reg   <= accepted_next;
            sequence_restart_reg <= restart_next;
        end
    end

`ifndef NO_ASSERTIONS
    // a restart flag only ever comes with an accepted frame
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!sequence_restart_reg || frame_accepted_reg))
        else $error("sequence restart without accepted frame");

    // every processed word lands in the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed word lost");

    // link reset always reports fault
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_op_reg == OP_LINK) |=> (status_reg == ST_FAULT))
        else $error("link reset did not report fault");

    // newline restarts the line parser
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_op_reg == OP_BYTE && in_byte_reg == CH_LF) |=>
        (phase_reg == PH_PRE_MAGIC && partial_length_reg == 12'd0))
        else $error("parser not restarted after newline");
`endif

endmodule

// File: tb/efm_checker.sv
// efm_checker: watches both channels of the frame monitor, predicts every result word
// and compares it field by field; counts mismatches and words still owed
// depends on efm_pkg
`timescale 1ns / 1ps

module efm_checker
    import efm_pkg::*;
#(
    parameter int SEQ_BITS = SEQ_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [7:0]  data_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  status,
    input  logic        frame_accepted,
    input  logic        sequence_restart,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          errors,
    output int          outstanding
);

    typedef enum logic [2:0] {
        PH_PRE_MAGIC, PH_MAGIC, PH_PRE_SEQ, PH_SEQ, PH_PRE_BTN, PH_BTN, PH_TAIL, PH_FAIL
    } phase_t;

    typedef struct packed {
        logic [1:0] status;
        logic       accepted;
        logic       restart;
    } status_word_t;

    localparam logic [63:0] SEQ_MAX    = (64'd1 << SEQ_BITS) - 64'd1;
    localparam logic [31:0] MAGIC_TEXT = "EST1";
    // button accumulator value for anything but a single 0 or 1
    localparam logic [1:0]  BTN_OVER   = 2'd2;

    logic [3:0]   debounce_cfg;
    logic [15:0]  timeout_cfg;
    logic [11:0]  line_limit_cfg;

    logic [11:0]  line_len;
    phase_t       phase;
    logic [2:0]   magic_pos;
    logic [63:0]  seq_acc;
    parse_flags_t flags;
    logic [1:0]   btn_acc;
    logic         seq_seen;
    logic [63:0]  seq_last;
    logic [1:0]   raw_btn;
    logic [1:0]   stable_btn;
    logic [3:0]   agree_cnt;
    logic [16:0]  hb_age;
    logic [1:0]   cur_status;

    status_word_t expected_words[$];

    function automatic logic is_blank(input logic [7:0] ch);
        return ch == CH_SPACE || ch == CH_TAB || ch == CH_VT || ch == CH_FF || ch == CH_CR;
    endfunction

    function automatic logic is_num(input logic [7:0] ch);
        return ch >= CH_ZERO && ch <= CH_NINE;
    endfunction

    function automatic void clear_line();
        line_len  = '0;
        phase     = PH_PRE_MAGIC;
        magic_pos = '0;
        seq_acc   = '0;
        flags     = '0;
        btn_acc   = 2'd0;
    endfunction

    function automatic void forget_history();
        clear_line();
        seq_seen   = 1'b0;
        seq_last   = '0;
        raw_btn    = BTN_NONE;
        stable_btn = BTN_NONE;
        agree_cnt  = '0;
        hb_age     = '0;
        cur_status = ST_FAULT;
    endfunction

    function automatic void start_number(input logic [7:0] ch, input phase_t nxt);
        flags = '0;
        if (ch == CH_PLUS || ch == CH_MINUS)
        begin
            flags.neg = (ch == CH_MINUS);
            phase     = nxt;
        end
        else if (is_num(ch))
            phase = nxt;
        else
            phase = PH_FAIL;
    endfunction

    function automatic void add_seq_digit(input logic [3:0] d);
        flags.digit = 1'b1;
        if (seq_acc > (SEQ_MAX - 64'(d)) / 64'd10)
            flags.bad = 1'b1;
        else
            seq_acc = seq_acc * 64'd10 + 64'(d);
    endfunction

    function automatic void add_btn_digit(input logic [3:0] d);
        flags.digit = 1'b1;
        if (btn_acc == 2'd0)
            btn_acc = (d >= 4'd2) ? BTN_OVER : d[1:0];
        else
            btn_acc = BTN_OVER;
    endfunction

    function automatic logic btn_valid();
        if (!flags.digit)
            return 1'b0;
        if (btn_acc == 2'd0)
            return 1'b1;
        return btn_acc == 2'd1 && !flags.neg;
    endfunction

    // token state machine; a token that ends falls through into the next phase
    function automatic void parse_char(input logic [7:0] ch);
        logic [3:0] d;
        d = 4'(ch - CH_ZERO);
        if (phase == PH_PRE_MAGIC)
        begin
            if (is_blank(ch))
                return;
            phase     = PH_MAGIC;
            magic_pos = '0;
            flags     = '0;
        end
        if (phase == PH_MAGIC)
        begin
            if (is_blank(ch))
                phase = (magic_pos == MAGIC_LEN && !flags.bad) ? PH_PRE_SEQ : PH_FAIL;
            else if (magic_pos < MAGIC_LEN
                     && ch == MAGIC_TEXT[8 * (3 - int'(magic_pos)) +: 8])
                magic_pos++;
            else
                flags.bad = 1'b1;
            return;
        end
        if (phase == PH_PRE_SEQ)
        begin
            if (is_blank(ch))
                return;
            seq_acc = '0;
            start_number(ch, PH_SEQ);
            if (phase == PH_SEQ && is_num(ch))
                add_seq_digit(d);
            return;
        end
        if (phase == PH_SEQ)
        begin
            if (is_num(ch))
            begin
                add_seq_digit(d);
                return;
            end
            // only zero may carry a minus sign
            if (!flags.digit || flags.bad || (flags.neg && seq_acc != '0))
            begin
                phase = PH_FAIL;
                return;
            end
            phase = PH_PRE_BTN;
        end
        if (phase == PH_PRE_BTN)
        begin
            if (is_blank(ch))
                return;
            btn_acc = 2'd0;
            start_number(ch, PH_BTN);
            if (phase == PH_BTN && is_num(ch))
                add_btn_digit(d);
            return;
        end
        if (phase == PH_BTN)
        begin
            if (is_num(ch))
            begin
                add_btn_digit(d);
                return;
            end
            if (!btn_valid())
            begin
                phase = PH_FAIL;
                return;
            end
            phase = PH_TAIL;
        end
        if (phase == PH_TAIL && !is_blank(ch))
            phase = PH_FAIL;
    endfunction

    function automatic status_word_t predict_status_word(input logic [1:0] op,
                                                         input logic [7:0] ch);
        status_word_t w;
        w = '0;
        case (op)
            OP_BYTE:
            begin
                if (ch == CH_LF)
                begin
                    if (phase == PH_TAIL || (phase == PH_BTN && btn_valid()))
                    begin
                        w.accepted = 1'b1;
                        // non-increasing sequence starts the debounce afresh
                        if (seq_seen && seq_acc <= seq_last)
                        begin
                            raw_btn    = BTN_NONE;
                            stable_btn = BTN_NONE;
                            agree_cnt  = '0;
                            w.restart  = 1'b1;
                        end
                        seq_last = seq_acc;
                        seq_seen = 1'b1;
                        hb_age   = '0;
                        if (btn_acc == raw_btn)
                        begin
                            if (agree_cnt < debounce_cfg)
                                agree_cnt++;
                        end
                        else
                        begin
                            raw_btn   = btn_acc;
                            agree_cnt = 4'd1;
                        end
                        if (agree_cnt >= debounce_cfg)
                            stable_btn = btn_acc;
                    end
                    clear_line();
                end
                else if (line_len >= line_limit_cfg)
                    clear_line();
                else
                begin
                    line_len++;
                    parse_char(ch);
                end
            end
            OP_TICK:
                if (hb_age != AGE_MAX)
                    hb_age++;
            OP_LINK:
                forget_history();
            default:
                ;
        endcase
        if (op == OP_BYTE || op == OP_TICK || op == OP_LINK)
        begin
            if (hb_age > {1'b0, timeout_cfg})
                cur_status = ST_FAULT;
            else if (stable_btn == 2'd0)
                cur_status = ST_PRESSED;
            else if (stable_btn == 2'd1)
                cur_status = ST_OK;
        end
        w.status = cur_status;
        return w;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $time, what);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        status_word_t want;
        if (!rst_n)
        begin
            debounce_cfg   = DEBOUNCE_RESET;
            timeout_cfg    = TIMEOUT_RESET;
            line_limit_cfg = LINE_LIM_RESET;
            forget_history();
            expected_words.delete();
            errors      = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DEBOUNCE: debounce_cfg   = cfg_data[3:0];
                    REG_TIMEOUT:  timeout_cfg    = cfg_data;
                    REG_LINE_LIM: line_limit_cfg = cfg_data[11:0];
                    default:      ;
                endcase
            end
            if (in_valid && !in_stall)
                expected_words.push_back(predict_status_word(operation, data_byte));
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                    report_mismatch("result word with nothing expected");
                else
                begin
                    want = expected_words.pop_front();
                    if (status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  status, want.status));
                    if (frame_accepted !== want.accepted)
                        report_mismatch($sformatf("frame_accepted %0b, expected %0b",
                                                  frame_accepted, want.accepted));
                    if (sequence_restart !== want.restart)
                        report_mismatch($sformatf("sequence_restart %0b, expected %0b",
                                                  sequence_restart, want.restart));
                end
            end
            outstanding <= expected_words.size();
        end
    end

endmodule

// File: tb/tb_top.sv
// tb_top: stimulus and verdict for the emergency-stop frame monitor core
// drives text frames, ticks and link resets under changing register settings
// depends on efm_pkg, estop_frame_monitor_core and efm_checker
`timescale 1ns / 1ps

module tb_top;
    import efm_pkg::*;

    // the block ignores this operation code, only the status is reported back
    localparam logic [1:0] OP_NONE = 2'd3;
    // cycles with no word moving on either channel before the run is abandoned
    localparam int WATCHDOG_LIMIT = 2000;
    // random words sent per register setting
    localparam int PHASE_WORDS = 290;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  operation = OP_BYTE;
    logic [7:0]  data_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic        frame_accepted;
    logic        sequence_restart;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_DEBOUNCE;
    logic [15:0] cfg_data = 16'h0000;

    int errors;
    int outstanding;

    // idling odds in percent for each side
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int phase_words = 0;
    int quiet_cycles = 0;

    // bytes of the line being built, sent in order by send_line
    logic [7:0]  line_buf[$];
    // running sequence number of well-formed frames
    logic [63:0] next_seq;
    // button level the sender is currently reporting
    logic        button_level;
    logic [15:0] timeout_now;

    estop_frame_monitor_core u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .operation        (operation),
        .data_byte        (data_byte),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .frame_accepted   (frame_accepted),
        .sequence_restart (sequence_restart),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    efm_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .operation        (operation),
        .data_byte        (data_byte),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .frame_accepted   (frame_accepted),
        .sequence_restart (sequence_restart),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .errors           (errors),
        .outstanding      (outstanding)
    );

    always #5 clk = ~clk;

    // receiver back-pressure, redrawn every cycle
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    // watchdog: any word moving on either side restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // offer one word, with a random gap in front, and hold it until taken
    task automatic send_word(input logic [1:0] op, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        data_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        phase_words++;
    endtask

    task automatic send_line();
        foreach (line_buf[i])
            send_word(OP_BYTE, line_buf[i]);
        line_buf.delete();
    endtask

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endfunction

    // one to most separator characters, about half of them plain spaces
    function automatic void put_blank(input int most);
        int n;
        n = $urandom_range(most, 1);
        repeat (n)
        begin
            case ($urandom_range(7))
                0:       line_buf.push_back(CH_TAB);
                1:       line_buf.push_back(CH_VT);
                2:       line_buf.push_back(CH_FF);
                3:       line_buf.push_back(CH_CR);
                default: line_buf.push_back(CH_SPACE);
            endcase
        end
    endfunction

    // a frame line, mostly well formed, with random spacing, signs and corner numbers
    function automatic void put_frame();
        int    r;
        int    k;
        string seq_txt;
        string btn_txt;
        if ($urandom_range(9) == 0)
            put_blank(2);
        put_text("EST1");
        // a wide gap now and then pushes the line past a short limit
        put_blank(($urandom_range(7) == 0) ? 12 : 2);

        r = $urandom_range(99);
        if (r < 70)
        begin
            next_seq += 64'($urandom_range(3, 1));
            seq_txt = $sformatf("%0d", next_seq);
        end
        else if (r < 80)
        begin
            // repeated or falling sequence
            k = $urandom_range(3, 0);
            seq_txt = $sformatf("%0d", (next_seq > 64'd3) ? next_seq - 64'(k) : next_seq);
        end
        else if (r < 84)
        begin
            case ($urandom_range(3))
                0:       seq_txt = "4294967295";
                1:       seq_txt = "4294967296";
                2:       seq_txt = "4294967294";
                default: seq_txt = "18446744073709551616";
            endcase
        end
        else if (r < 90)
        begin
            case ($urandom_range(3))
                0:       seq_txt = "-0";
                1:       seq_txt = "-000";
                2:       seq_txt = "-7";
                default: seq_txt = "-";
            endcase
        end
        else if (r < 95)
        begin
            next_seq += 64'd1;
            seq_txt = $sformatf("+%0d", next_seq);
        end
        else
        begin
            next_seq += 64'd1;
            seq_txt = $sformatf("00%0d", next_seq);
        end
        put_text(seq_txt);
        // no separator at times, so the number runs into the next token
        if ($urandom_range(19) != 0)
            put_blank(2);

        if ($urandom_range(19) == 0)
            button_level = ~button_level;
        r = $urandom_range(99);
        if (r < 80)
            btn_txt = $sformatf("%0d", button_level);
        else if (r < 84)
            btn_txt = $sformatf("+%0d", button_level);
        else if (r < 88)
            btn_txt = "-0";
        else if (r < 91)
            btn_txt = $sformatf("0%0d", button_level);
        else if (r < 94)
            btn_txt = "-1";
        else if (r < 96)
            btn_txt = "2";
        else if (r < 98)
            btn_txt = "10";
        else
            btn_txt = "1x";
        put_text(btn_txt);

        if ($urandom_range(4) == 0)
            put_blank(2);
        if ($urandom_range(29) == 0)
            put_text(" 9");
        line_buf.push_back(CH_LF);
    endfunction

    // let every owed word come back, then write all three registers
    task automatic settle_and_configure(input logic [3:0] deb, input logic [15:0] tmo,
                                        input logic [11:0] lim);
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_DEBOUNCE;
        cfg_data  <= {12'h000, deb};
        @(posedge clk);
        cfg_index <= REG_TIMEOUT;
        cfg_data  <= tmo;
        @(posedge clk);
        cfg_index <= REG_LINE_LIM;
        cfg_data  <= {4'h0, lim};
        @(posedge clk);
        cfg_we <= 1'b0;
        timeout_now = tmo;
    endtask

    initial
    begin
        int         kind;
        int         n;
        int         idx;
        logic [3:0]  deb;
        logic [15:0] tmo;
        logic [11:0] lim;

        next_seq     = 64'd10;
        button_level = 1'b1;
        timeout_now  = TIMEOUT_RESET;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words: signed zero and a plus sign, a number running into the
        // button token, extremes of the byte, a tick, the ignored operation and a link reset
        send_idle_pct = 8;
        recv_idle_pct = 58;
        put_text("EST1 -0 +1");
        line_buf.push_back(CH_LF);
        put_text("EST1 5+0");
        line_buf.push_back(CH_LF);
        send_line();
        send_word(OP_TICK, 8'hFF);
        send_word(OP_NONE, 8'h00);
        send_word(OP_BYTE, 8'h00);
        send_word(OP_BYTE, 8'hFF);
        send_word(OP_LINK, 8'h5A);

        for (int p = 0; p < 6; p++)
        begin
            // register settings per phase; the first keeps the reset values
            case (p)
                1:       begin deb = 4'd1;  tmo = 16'd20;    lim = 12'd16;   end
                2:       begin deb = 4'd15; tmo = 16'hFFFF;  lim = 12'd4095; end
                3:       begin deb = 4'd0;  tmo = 16'd0;     lim = 12'd40;   end
                4:       begin deb = 4'd2;  tmo = 16'd5;     lim = 12'd16;   end
                default: begin deb = 4'd4;  tmo = 16'd1;     lim = 12'd64;   end
            endcase
            if (p != 0)
                settle_and_configure(deb, tmo, lim);

            // sender idles lightly first, then the receiver does, then neither
            if (p < 2)
            begin
                send_idle_pct = 8;
                recv_idle_pct = 58;
            end
            else if (p < 4)
            begin
                send_idle_pct = 58;
                recv_idle_pct = 8;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            phase_words = 0;
            while (phase_words < PHASE_WORDS)
            begin
                kind = $urandom_range(99);
                if (kind < 86)
                begin
                    put_frame();
                    // broken frames: a byte replaced, dropped or added, or the newline lost
                    if (kind >= 72)
                    begin
                        idx = $urandom_range(line_buf.size() - 2);
                        case ($urandom_range(3))
                            0:       line_buf[idx] = 8'($urandom_range(255));
                            1:       line_buf.delete(idx);
                            2:       line_buf.insert(idx, 8'($urandom_range(126, 33)));
                            default: void'(line_buf.pop_back());
                        endcase
                    end
                    send_line();
                end
                else if (kind < 90)
                begin
                    // line noise of any byte value
                    n = $urandom_range(40, 1);
                    repeat (n) line_buf.push_back(8'($urandom_range(255)));
                    line_buf.push_back(CH_LF);
                    send_line();
                end
                else if (kind < 96)
                begin
                    // a burst long enough to cross a short heartbeat timeout now and then
                    if ($urandom_range(3) == 0 && timeout_now < 150)
                        n = int'(timeout_now) + 2;
                    else
                        n = $urandom_range(3, 1);
                    repeat (n) send_word(OP_TICK, 8'($urandom_range(255)));
                end
                else if (kind < 98)
                    send_word(OP_LINK, 8'($urandom_range(255)));
                else
                    send_word(OP_NONE, 8'($urandom_range(255)));

                // occasional heartbeat ticks between lines
                if ($urandom_range(2) == 0)
                    send_word(OP_TICK, 8'($urandom_range(255)));
            end
        end

        // drain: every owed word back, then a short wait for stray output
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: files.f
design/efm_pkg.sv
design/estop_frame_monitor_core.sv
tb/efm_checker.sv
tb/tb_top.sv
